@@ src/hardware_semaphore_bank_defines.svh @@
// Assertion macros for the semaphore bank.
// No dependencies; included by the top level only.
`ifndef HARDWARE_SEMAPHORE_BANK_DEFINES_SVH
`define HARDWARE_SEMAPHORE_BANK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define HSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsb: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define HSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsb: next-cycle check failed");

`else

`define HSB_ASSERT_NOW(label, clk, rst, ante, cons)
`define HSB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/hsb_pkg.sv @@
// Shared types and constants of the semaphore bank.
// No dependencies.
`timescale 1ns / 1ps

package hsb_pkg;

   localparam int NUM_SEMAPHORES_DEF = 32;

   localparam int DATA_W  = 32;
   localparam int GROUP_W = 4;
   localparam int INDEX_W = 5;
   localparam int CORE_W  = 4;
   localparam int PROC_W  = 8;
   localparam int KEY_W   = 16;

   localparam int KEY_LSB  = 16;
   localparam int CORE_LSB = 8;
   localparam int LOCK_POS = 31;

   // access kinds
   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   // register groups
   localparam logic [GROUP_W-1:0] GRP_LOCK       = 4'd0;
   localparam logic [GROUP_W-1:0] GRP_READLOCK   = 4'd1;
   localparam logic [GROUP_W-1:0] GRP_C1_ENABLE  = 4'd2;
   localparam logic [GROUP_W-1:0] GRP_C1_CLEAR   = 4'd3;
   localparam logic [GROUP_W-1:0] GRP_C1_STATUS  = 4'd4;
   localparam logic [GROUP_W-1:0] GRP_C1_MASKED  = 4'd5;
   localparam logic [GROUP_W-1:0] GRP_C2_ENABLE  = 4'd6;
   localparam logic [GROUP_W-1:0] GRP_C2_CLEAR   = 4'd7;
   localparam logic [GROUP_W-1:0] GRP_C2_STATUS  = 4'd8;
   localparam logic [GROUP_W-1:0] GRP_C2_MASKED  = 4'd9;
   localparam logic [GROUP_W-1:0] GRP_UNLOCK_ALL = 4'd10;
   localparam logic [GROUP_W-1:0] GRP_KEY        = 4'd11;

   // commands to the semaphore store
   typedef struct packed {
      logic                wr_lock;
      logic                wr_unlock;
      logic                rd_sem;
      logic                rd_lock;
      logic                unlock_all;
      logic [INDEX_W-1:0]  index;
      logic [CORE_W-1:0]   core;
      logic [PROC_W-1:0]   proc;
      logic [CORE_W-1:0]   master;
   } sem_cmd_type;

   // access to the interrupt and key registers
   typedef struct packed {
      logic                valid;
      logic                write;
      logic [GROUP_W-1:0]  group;
      logic [DATA_W-1:0]   data;
   } reg_cmd_type;

endpackage

@@ src/hsb_sem_array.sv @@
// Semaphore store: taken flags and owners, lock, unlock and unlock-all.
// Depends on hsb_pkg.
`timescale 1ns / 1ps

module hsb_sem_array #(
   parameter int NUM_SEMAPHORES = hsb_pkg::NUM_SEMAPHORES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hsb_pkg::sem_cmd_type       sem_cmd,
   output logic [hsb_pkg::DATA_W-1:0] sem_word,
   output logic [NUM_SEMAPHORES-1:0]  freed
);

   localparam int IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
   localparam logic [hsb_pkg::INDEX_W:0] NUM_LIM = (hsb_pkg::INDEX_W + 1)'(NUM_SEMAPHORES);

   logic [NUM_SEMAPHORES-1:0]     taken_ff;
   logic [NUM_SEMAPHORES-1:0]     taken_in;
   logic [hsb_pkg::CORE_W-1:0]    owner_core_ff [NUM_SEMAPHORES];
   logic [hsb_pkg::PROC_W-1:0]    owner_proc_ff [NUM_SEMAPHORES];

   logic                          in_range;
   logic [IDX_W-1:0]              sel;
   logic                          cur_taken;
   logic [hsb_pkg::CORE_W-1:0]    cur_core;
   logic [hsb_pkg::PROC_W-1:0]    cur_proc;
   logic                          take;
   logic [hsb_pkg::CORE_W-1:0]    take_core;
   logic [hsb_pkg::PROC_W-1:0]    take_proc;
   logic                          unlock_hit;

   assign in_range  = ({1'b0, sem_cmd.index} < NUM_LIM);
   assign sel       = sem_cmd.index[IDX_W-1:0];
   assign cur_taken = in_range && taken_ff[sel];
   assign cur_core  = owner_core_ff[sel];
   assign cur_proc  = owner_proc_ff[sel];

   always_comb begin
      take       = 1'b0;
      take_core  = sem_cmd.core;
      take_proc  = sem_cmd.proc;
      unlock_hit = 1'b0;
      if (in_range && !cur_taken) begin
         if (sem_cmd.wr_lock) begin
            take = 1'b1;
         end else if (sem_cmd.rd_lock) begin
            take      = 1'b1;
            take_core = sem_cmd.master;
            take_proc = '0;
         end
      end
      if (sem_cmd.wr_unlock && cur_taken && cur_core == sem_cmd.core &&
          cur_proc == sem_cmd.proc) begin
         unlock_hit = 1'b1;
      end
   end

   always_comb begin
      freed = '0;
      if (unlock_hit) begin
         freed[sel] = 1'b1;
      end
      if (sem_cmd.unlock_all) begin
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            if (taken_ff[i] && owner_core_ff[i] == sem_cmd.core) begin
               freed[i] = 1'b1;
            end
         end
      end
      taken_in = taken_ff & ~freed;
      if (take) begin
         taken_in[sel] = 1'b1;
      end
   end

   // word after the access; a free semaphore reads zero, but a read-lock takes it and reads the new owner
   always_comb begin
      sem_word = '0;
      if (cur_taken && (sem_cmd.rd_sem || sem_cmd.rd_lock)) begin
         sem_word = {1'b1, 19'd0, cur_core, cur_proc};
      end else if (take && sem_cmd.rd_lock) begin
         sem_word = {1'b1, 19'd0, take_core, take_proc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
      end else begin
         taken_ff <= taken_in;
      end
   end

   // owner fields only mean something while taken
   always_ff @(posedge clock) begin
      if (take) begin
         owner_core_ff[sel] <= take_core;
         owner_proc_ff[sel] <= take_proc;
      end
   end

endmodule

@@ src/hsb_ctrl_regs.sv @@
// Interrupt enable/status registers of both cores and the unlock key.
// Depends on hsb_pkg.
`timescale 1ns / 1ps

module hsb_ctrl_regs #(
   parameter int NUM_SEMAPHORES = hsb_pkg::NUM_SEMAPHORES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hsb_pkg::reg_cmd_type       reg_cmd,
   input  logic [NUM_SEMAPHORES-1:0]  freed,
   output logic [hsb_pkg::DATA_W-1:0] reg_rdata,
   output logic                       key_match
);

   logic [NUM_SEMAPHORES-1:0] c1_enable_ff, c1_enable_in;
   logic [NUM_SEMAPHORES-1:0] c2_enable_ff, c2_enable_in;
   logic [NUM_SEMAPHORES-1:0] c1_status_ff, c1_status_in;
   logic [NUM_SEMAPHORES-1:0] c2_status_ff, c2_status_in;
   logic [hsb_pkg::KEY_W-1:0] key_ff, key_in;

   logic                      wr;
   logic [NUM_SEMAPHORES-1:0] wr_bits;
   logic [hsb_pkg::KEY_W-1:0] wr_key;

   assign wr      = reg_cmd.valid && (reg_cmd.write == hsb_pkg::ACC_WRITE);
   assign wr_bits = reg_cmd.data[NUM_SEMAPHORES-1:0];
   assign wr_key  = reg_cmd.data[hsb_pkg::KEY_LSB +: hsb_pkg::KEY_W];

   assign key_match = (wr_key == key_ff);

   always_comb begin
      c1_enable_in = c1_enable_ff;
      c2_enable_in = c2_enable_ff;
      c1_status_in = c1_status_ff | freed;
      c2_status_in = c2_status_ff | freed;
      key_in       = key_ff;
      if (wr) begin
         case (reg_cmd.group)
            hsb_pkg::GRP_C1_ENABLE: begin
               c1_enable_in = wr_bits;
            end
            hsb_pkg::GRP_C2_ENABLE: begin
               c2_enable_in = wr_bits;
            end
            hsb_pkg::GRP_C1_CLEAR: begin
               c1_status_in = (c1_status_ff & ~wr_bits) | freed;
            end
            hsb_pkg::GRP_C2_CLEAR: begin
               c2_status_in = (c2_status_ff & ~wr_bits) | freed;
            end
            hsb_pkg::GRP_KEY: begin
               key_in = wr_key;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      reg_rdata = '0;
      case (reg_cmd.group)
         hsb_pkg::GRP_C1_ENABLE: reg_rdata = hsb_pkg::DATA_W'(c1_enable_ff);
         hsb_pkg::GRP_C1_STATUS: reg_rdata = hsb_pkg::DATA_W'(c1_status_ff);
         hsb_pkg::GRP_C1_MASKED: reg_rdata = hsb_pkg::DATA_W'(c1_status_ff & c1_enable_ff);
         hsb_pkg::GRP_C2_ENABLE: reg_rdata = hsb_pkg::DATA_W'(c2_enable_ff);
         hsb_pkg::GRP_C2_STATUS: reg_rdata = hsb_pkg::DATA_W'(c2_status_ff);
         hsb_pkg::GRP_C2_MASKED: reg_rdata = hsb_pkg::DATA_W'(c2_status_ff & c2_enable_ff);
         hsb_pkg::GRP_KEY:       reg_rdata = {key_ff, 16'd0};
         default:                reg_rdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_enable_ff <= '0;
         c2_enable_ff <= '0;
         c1_status_ff <= '0;
         c2_status_ff <= '0;
         key_ff       <= '0;
      end else begin
         c1_enable_ff <= c1_enable_in;
         c2_enable_ff <= c2_enable_in;
         c1_status_ff <= c1_status_in;
         c2_status_ff <= c2_status_in;
         key_ff       <= key_in;
      end
   end

endmodule

@@ src/hardware_semaphore_bank.sv @@
// Top level of the two-core hardware semaphore bank.
// Depends on hsb_pkg, hsb_sem_array, hsb_ctrl_regs and the assertion header.
//
// Use:
//  - Request channel: a bus access (req_access_kind, req_reg_group, req_sem_index,
//    req_write_data, req_master_core) is taken at a rising edge with start high
//    and busy low. busy is never raised: one access is taken every clock.
//  - Response channel: exactly one word per access on rsp_read_data, shown for
//    one cycle with rsp_strobe high. Writes answer with a zero word.
//  - Path: the access is registered in the input register at the accepting edge,
//    processed by the semaphore store and register block, and its word registered
//    in the result register, which drives rsp_strobe.
//  - Throughput: one access per clock, sustained. State changes of one access
//    are visible to the next, as both pass the same single logic stage.
//  - Reset (synchronous, active high): all semaphores free, enable, status
//    and key registers zero, no response pending.
//  - The receiver cannot stall: every word is taken when it is shown.
`timescale 1ns / 1ps
`include "hardware_semaphore_bank_defines.svh"

module hardware_semaphore_bank #(
   parameter int NUM_SEMAPHORES = hsb_pkg::NUM_SEMAPHORES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_access_kind,
   input  logic [hsb_pkg::GROUP_W-1:0] req_reg_group,
   input  logic [hsb_pkg::INDEX_W-1:0] req_sem_index,
   input  logic [hsb_pkg::DATA_W-1:0]  req_write_data,
   input  logic [hsb_pkg::CORE_W-1:0]  req_master_core,
   output logic                        rsp_strobe,
   output logic [hsb_pkg::DATA_W-1:0]  rsp_read_data
);

   // input register
   logic                        req_valid_ff;
   logic                        req_kind_ff;
   logic [hsb_pkg::GROUP_W-1:0] req_group_ff;
   logic [hsb_pkg::INDEX_W-1:0] req_index_ff;
   logic [hsb_pkg::DATA_W-1:0]  req_data_ff;
   logic [hsb_pkg::CORE_W-1:0]  req_master_ff;

   // result register
   logic                        rsp_strobe_ff;
   logic [hsb_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        is_wr, is_rd;
   logic [hsb_pkg::CORE_W-1:0]  d_core;
   logic [hsb_pkg::PROC_W-1:0]  d_proc;
   logic                        core_ok;
   logic                        key_match;

   hsb_pkg::sem_cmd_type        sem_cmd;
   hsb_pkg::reg_cmd_type        reg_cmd;
   logic [hsb_pkg::DATA_W-1:0]  sem_word;
   logic [hsb_pkg::DATA_W-1:0]  reg_rdata;
   logic [NUM_SEMAPHORES-1:0]   freed;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_kind_ff   <= req_access_kind;
         req_group_ff  <= req_reg_group;
         req_index_ff  <= req_sem_index;
         req_data_ff   <= req_write_data;
         req_master_ff <= req_master_core;
      end
   end

   // decode of the registered access
   assign is_wr   = req_valid_ff && (req_kind_ff == hsb_pkg::ACC_WRITE);
   assign is_rd   = req_valid_ff && (req_kind_ff == hsb_pkg::ACC_READ);
   assign d_core  = req_data_ff[hsb_pkg::CORE_LSB +: hsb_pkg::CORE_W];
   assign d_proc  = req_data_ff[hsb_pkg::PROC_W-1:0];
   assign core_ok = (d_core == req_master_ff);

   always_comb begin
      sem_cmd.wr_lock    = is_wr && (req_group_ff == hsb_pkg::GRP_LOCK) && core_ok &&
                           req_data_ff[hsb_pkg::LOCK_POS];
      sem_cmd.wr_unlock  = is_wr && (req_group_ff == hsb_pkg::GRP_LOCK) && core_ok &&
                           !req_data_ff[hsb_pkg::LOCK_POS];
      sem_cmd.rd_sem     = is_rd && (req_group_ff == hsb_pkg::GRP_LOCK);
      sem_cmd.rd_lock    = is_rd && (req_group_ff == hsb_pkg::GRP_READLOCK);
      // key compare comes from the register block, off the same write word
      sem_cmd.unlock_all = is_wr && (req_group_ff == hsb_pkg::GRP_UNLOCK_ALL) && key_match;
      sem_cmd.index      = req_index_ff;
      sem_cmd.core       = d_core;
      sem_cmd.proc       = d_proc;
      sem_cmd.master     = req_master_ff;
   end

   always_comb begin
      reg_cmd.valid = req_valid_ff;
      reg_cmd.write = req_kind_ff;
      reg_cmd.group = req_group_ff;
      reg_cmd.data  = req_data_ff;
   end

   hsb_sem_array #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES)
   ) u_sem_array (
      .clock    (clock),
      .reset    (reset),
      .sem_cmd  (sem_cmd),
      .sem_word (sem_word),
      .freed    (freed)
   );

   hsb_ctrl_regs #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES)
   ) u_ctrl_regs (
      .clock     (clock),
      .reset     (reset),
      .reg_cmd   (reg_cmd),
      .freed     (freed),
      .reg_rdata (reg_rdata),
      .key_match (key_match)
   );

   // read word select: writes always answer zero
   always_comb begin
      rsp_data_in = '0;
      if (req_kind_ff == hsb_pkg::ACC_READ) begin
         if (req_group_ff == hsb_pkg::GRP_LOCK || req_group_ff == hsb_pkg::GRP_READLOCK) begin
            rsp_data_in = sem_word;
         end else begin
            rsp_data_in = reg_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_data = rsp_data_ff;

   // checks
   `HSB_ASSERT_NEXT(a_accept_reaches_stage, clock, reset, accept, req_valid_ff)
   `HSB_ASSERT_NEXT(a_stage_gives_word, clock, reset, req_valid_ff, rsp_strobe)
   `HSB_ASSERT_NOW(a_word_has_source, clock, reset, rsp_strobe, $past(req_valid_ff))
   `HSB_ASSERT_NEXT(a_write_reads_zero, clock, reset, is_wr, rsp_read_data == '0)
   `HSB_ASSERT_NOW(a_free_needs_write, clock, reset, freed != '0, is_wr)

endmodule
